// ===== src/hxmm_pkg.sv =====
// ----------------------------------------------------------------------------
// Hexacopter X motor mixer package
// Widths, mixing coefficients, register indexes and reset values shared by the
// mixer, together with the Q.15 truncation helper.
// ----------------------------------------------------------------------------
package hxmm_pkg;

  localparam int CmdW    = 12;  // throttle, stick, limits and motor width
  localparam int TermW   = 14;  // roll, pitch and yaw correction width
  localparam int SumW    = 32;  // Q.15 motor sum width
  localparam int MixW    = 17;  // integer motor value before limiting
  localparam int LimW    = 18;  // motor value after the excess shift
  localparam int CoefW   = 16;  // signed width of the Q1.15 coefficients
  localparam int ProdW   = TermW + CoefW;
  localparam int NMotors = 6;
  localparam int InDataW  = 72;
  localparam int OutDataW = 72;
  localparam int CfgIdxW  = 2;

  localparam logic signed [CoefW-1:0] QCos30 = 16'sd28377;
  localparam logic [CmdW-1:0] IdleCmd = 12'd1000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MIN_THROTTLE    = 2'd0,
    REG_MAX_THROTTLE    = 2'd1,
    REG_STICK_MIN_CHECK = 2'd2
  } cfg_reg_t;

  localparam logic [CmdW-1:0] MinThrottleRst   = 12'd1100;
  localparam logic [CmdW-1:0] MaxThrottleRst   = 12'd1900;
  localparam logic [CmdW-1:0] StickMinCheckRst = 12'd1100;

  typedef logic signed [MixW-1:0] mix_t;

  // Divides a Q.15 value by 2^15, rounding toward zero.
  function automatic mix_t q15_trunc(input logic signed [SumW-1:0] q);
    logic signed [SumW-1:0] adj;
    adj = q[SumW-1] ? q + 32'sd32767 : q;
    return adj[SumW-1:15];
  endfunction

endpackage

// ===== src/hex_x_motor_mixer.sv =====
// ----------------------------------------------------------------------------
// Hexacopter X motor mixer
// Mixes throttle with roll, pitch and yaw terms into six limited motor
// commands in a four-stage pipeline.
// ----------------------------------------------------------------------------
// The mixer takes one request per clock while the output is not stalled and
// returns one result per request. An accepted request is registered in
// stages one to four in turn and the result is driven from stage four. Stage one
// forms the 0.866 pitch product (the one multiplier) and decides the idle
// override, stage two adds the six Q.15 sums and truncates them toward zero,
// stage three finds the largest motor, and stage four shifts all motors down
// by any excess above max_throttle, clamps them to the limits and applies the
// idle command of 1000. Each stage holds its own valid bit and moves forward
// when the stage after it is empty or moving, so bubbles close up and an
// output stall backs up through the pipeline without losing or repeating a
// request. The limit registers are written through the plain write port and
// should be changed only while no request is in flight.
module hex_x_motor_mixer (
  input  logic                              clk,
  input  logic                              rst,
  // base_throttle[11:0], roll_term[25:12], pitch_term[39:26],
  // yaw_term[53:40], armed[54], alt_hold[55], stick_throttle[67:56], zero fill
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [hxmm_pkg::InDataW-1:0]      s_axis_tdata,
  // motor0[11:0], motor1[23:12], motor2[35:24], motor3[47:36],
  // motor4[59:48], motor5[71:60]
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [hxmm_pkg::OutDataW-1:0]     m_axis_tdata,
  input  logic                              cfg_we,
  input  logic [hxmm_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [hxmm_pkg::CmdW-1:0]         cfg_data
);

  // Configuration registers.
  logic [hxmm_pkg::CmdW-1:0] min_throttle;
  logic [hxmm_pkg::CmdW-1:0] max_throttle;
  logic [hxmm_pkg::CmdW-1:0] stick_min_check;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_throttle    <= hxmm_pkg::MinThrottleRst;
      max_throttle    <= hxmm_pkg::MaxThrottleRst;
      stick_min_check <= hxmm_pkg::StickMinCheckRst;
    end else if (cfg_we) begin
      unique case (hxmm_pkg::cfg_reg_t'(cfg_index))
        hxmm_pkg::REG_MIN_THROTTLE:    min_throttle    <= cfg_data;
        hxmm_pkg::REG_MAX_THROTTLE:    max_throttle    <= cfg_data;
        hxmm_pkg::REG_STICK_MIN_CHECK: stick_min_check <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input fields.
  logic [hxmm_pkg::CmdW-1:0]         in_base;
  logic signed [hxmm_pkg::TermW-1:0] in_roll;
  logic signed [hxmm_pkg::TermW-1:0] in_pitch;
  logic signed [hxmm_pkg::TermW-1:0] in_yaw;
  logic                              in_armed;
  logic                              in_hold;
  logic [hxmm_pkg::CmdW-1:0]         in_stick;

  assign in_base  = s_axis_tdata[11:0];
  assign in_roll  = s_axis_tdata[25:12];
  assign in_pitch = s_axis_tdata[39:26];
  assign in_yaw   = s_axis_tdata[53:40];
  assign in_armed = s_axis_tdata[54];
  assign in_hold  = s_axis_tdata[55];
  assign in_stick = s_axis_tdata[67:56];

  // Stage valid bits and the ready chain: a stage may load when it is empty
  // or when its contents move on in the same cycle.
  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !v4 || m_axis_tready;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign s_axis_tready = rdy1;
  assign m_axis_tvalid = v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= s_axis_tvalid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  // Stage one: pitch product and the idle decision.
  logic [hxmm_pkg::CmdW-1:0]         t1;
  logic signed [hxmm_pkg::TermW-1:0] r1;
  logic signed [hxmm_pkg::TermW-1:0] y1;
  logic signed [hxmm_pkg::ProdW-1:0] cp1;
  logic                              idle1;

  // Both factors are sign-extended to the product width.
  logic signed [hxmm_pkg::ProdW-1:0] pitch_w;
  logic signed [hxmm_pkg::ProdW-1:0] cos30_w;

  assign pitch_w = {{(hxmm_pkg::ProdW-hxmm_pkg::TermW){in_pitch[hxmm_pkg::TermW-1]}},
                    in_pitch};
  assign cos30_w = {{(hxmm_pkg::ProdW-hxmm_pkg::CoefW){hxmm_pkg::QCos30[hxmm_pkg::CoefW-1]}},
                    hxmm_pkg::QCos30};

  always_ff @(posedge clk) begin
    if (rdy1 && s_axis_tvalid) begin
      t1    <= in_base;
      r1    <= in_roll;
      y1    <= in_yaw;
      cp1   <= pitch_w * cos30_w;
      idle1 <= !in_armed || (!in_hold && (in_stick < stick_min_check));
    end
  end

  // Stage two: the six Q.15 sums, truncated toward zero. The throttle and
  // the unit-weight terms are placed at 2^15, the half-weight roll at 2^14.
  logic signed [hxmm_pkg::SumW-1:0] tq, hr, fr, fy, cpx;
  logic signed [hxmm_pkg::SumW-1:0] q [hxmm_pkg::NMotors];

  assign tq  = {5'b0, t1, 15'b0};
  assign hr  = {{4{r1[hxmm_pkg::TermW-1]}}, r1, 14'b0};
  assign fr  = {{3{r1[hxmm_pkg::TermW-1]}}, r1, 15'b0};
  assign fy  = {{3{y1[hxmm_pkg::TermW-1]}}, y1, 15'b0};
  assign cpx = {{2{cp1[hxmm_pkg::ProdW-1]}}, cp1};

  always_comb begin
    q[0] = tq + hr + cpx - fy;
    q[1] = tq - hr - cpx + fy;
    q[2] = tq - hr + cpx + fy;
    q[3] = tq + hr - cpx - fy;
    q[4] = tq + fr + fy;
    q[5] = tq - fr - fy;
  end

  hxmm_pkg::mix_t m2 [hxmm_pkg::NMotors];
  logic           idle2;

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      for (int i = 0; i < hxmm_pkg::NMotors; i++) begin
        m2[i] <= hxmm_pkg::q15_trunc(q[i]);
      end
      idle2 <= idle1;
    end
  end

  // Stage three: the largest motor, through a small compare tree.
  hxmm_pkg::mix_t mx_a, mx_b, mx_c, mx_ab, mx_all;

  always_comb begin
    mx_a   = (m2[1] > m2[0]) ? m2[1] : m2[0];
    mx_b   = (m2[3] > m2[2]) ? m2[3] : m2[2];
    mx_c   = (m2[5] > m2[4]) ? m2[5] : m2[4];
    mx_ab  = (mx_b > mx_a) ? mx_b : mx_a;
    mx_all = (mx_c > mx_ab) ? mx_c : mx_ab;
  end

  hxmm_pkg::mix_t m3 [hxmm_pkg::NMotors];
  hxmm_pkg::mix_t mx3;
  logic           idle3;

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      m3    <= m2;
      mx3   <= mx_all;
      idle3 <= idle2;
    end
  end

  // Stage four: excess shift, clamp (floor first, then ceiling) and the idle
  // override, which wins over both limits.
  logic signed [hxmm_pkg::LimW-1:0] lo, hi, mxw;
  logic signed [hxmm_pkg::LimW-1:0] excess;
  logic signed [hxmm_pkg::LimW-1:0] sv [hxmm_pkg::NMotors];
  logic [hxmm_pkg::CmdW-1:0]        mot [hxmm_pkg::NMotors];

  assign lo     = {{(hxmm_pkg::LimW-hxmm_pkg::CmdW){1'b0}}, min_throttle};
  assign hi     = {{(hxmm_pkg::LimW-hxmm_pkg::CmdW){1'b0}}, max_throttle};
  assign mxw    = {mx3[hxmm_pkg::MixW-1], mx3};
  assign excess = (mxw > hi) ? (mxw - hi) : '0;

  always_comb begin
    for (int i = 0; i < hxmm_pkg::NMotors; i++) begin
      sv[i] = {m3[i][hxmm_pkg::MixW-1], m3[i]} - excess;
      if (sv[i] < lo) sv[i] = lo;
      if (sv[i] > hi) sv[i] = hi;
      mot[i] = idle3 ? hxmm_pkg::IdleCmd : sv[i][hxmm_pkg::CmdW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3) begin
      m_axis_tdata <= {mot[5], mot[4], mot[3], mot[2], mot[1], mot[0]};
    end
  end

endmodule
